// ===== hdl/aat_pkg.sv =====
// shared types, constants and helpers for the box transform unit
// no dependencies; used by every module under hdl
package aat_pkg;

    localparam int COORD_WIDTH     = 32;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int PIPE_DEPTH      = 6;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    localparam coord_t COORD_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam coord_t COORD_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        CFG_BOX_MIN_X = 3'd0,
        CFG_BOX_MIN_Y = 3'd1,
        CFG_BOX_MIN_Z = 3'd2,
        CFG_BOX_MAX_X = 3'd3,
        CFG_BOX_MAX_Y = 3'd4,
        CFG_BOX_MAX_Z = 3'd5
    } cfg_index_t;

    typedef struct packed {
        coord_t m00;
        coord_t m01;
        coord_t m02;
        coord_t m10;
        coord_t m11;
        coord_t m12;
        coord_t m20;
        coord_t m21;
        coord_t m22;
        coord_t trans_x;
        coord_t trans_y;
        coord_t trans_z;
    } in_t;

    typedef struct packed {
        coord_t world_min_x;
        coord_t world_min_y;
        coord_t world_min_z;
        coord_t world_max_x;
        coord_t world_max_y;
        coord_t world_max_z;
    } out_t;

    function automatic coord_t sat_add(coord_t a, coord_t b);
        logic [COORD_WIDTH:0] s;
        s = {a[COORD_WIDTH-1], a} + {b[COORD_WIDTH-1], b};
        if (s[COORD_WIDTH] != s[COORD_WIDTH-1])
            return s[COORD_WIDTH] ? COORD_MIN : COORD_MAX;
        return coord_t'(s[COORD_WIDTH-1:0]);
    endfunction

endpackage

// ===== hdl/aat_fx_mul.sv =====
// two-stage fixed-point multiplier: registered product, then round half away and saturate
// depends on aat_pkg
module aat_fx_mul #(
    parameter int FRAC_BITS = 16
) (
    input  logic           clk,
    input  logic           en,
    input  aat_pkg::coord_t a,
    input  aat_pkg::coord_t b,
    output aat_pkg::coord_t y
);

    localparam int CW = aat_pkg::COORD_WIDTH;
    localparam int PW = 2 * CW;
    localparam int RW = PW + 1 - FRAC_BITS;
    localparam logic [PW:0] HALF = (PW+1)'(1) << (FRAC_BITS - 1);

    logic signed [PW-1:0] prod_reg;
    logic signed [PW-1:0] prod_next;
    aat_pkg::coord_t      y_reg;
    aat_pkg::coord_t      y_next;

    logic          neg;
    logic [PW-1:0] mag;
    logic [PW:0]   rnd;
    logic [RW-1:0] rmag;
    logic [RW-1:0] lim;

    assign prod_next = a * b;

    always_comb
    begin
        neg  = prod_reg[PW-1];
        mag  = neg ? PW'(-prod_reg) : PW'(prod_reg);
        rnd  = {1'b0, mag} + HALF;
        rmag = rnd[PW:FRAC_BITS];
        lim  = RW'(aat_pkg::COORD_MAX) + RW'(neg);
        if (rmag > lim)
            y_next = neg ? aat_pkg::COORD_MIN : aat_pkg::COORD_MAX;
        else if (neg)
            y_next = aat_pkg::coord_t'(-rmag[CW-1:0]);
        else
            y_next = aat_pkg::coord_t'(rmag[CW-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= prod_next;
            y_reg    <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// ===== hdl/aat_axis.sv =====
// one output axis: six products, per-term min/max pick, three saturating add stages
// depends on aat_pkg and aat_fx_mul
module aat_axis #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  en,
    input  aat_pkg::coord_t [2:0] box_lo,
    input  aat_pkg::coord_t [2:0] box_hi,
    input  aat_pkg::coord_t [2:0] col,
    input  aat_pkg::coord_t       trans,
    output aat_pkg::coord_t       lo,
    output aat_pkg::coord_t       hi
);

    aat_pkg::coord_t [2:0] prod_lo;
    aat_pkg::coord_t [2:0] prod_hi;
    aat_pkg::coord_t [2:0] term_min_next;
    aat_pkg::coord_t [2:0] term_max_next;
    aat_pkg::coord_t [2:0] term_min_reg;
    aat_pkg::coord_t [2:0] term_max_reg;
    aat_pkg::coord_t [4:0] trans_pipe_reg;
    aat_pkg::coord_t       sum_min_reg;
    aat_pkg::coord_t       sum_max_reg;
    aat_pkg::coord_t       last_min_reg;
    aat_pkg::coord_t       last_max_reg;
    aat_pkg::coord_t       sum2_min_reg;
    aat_pkg::coord_t       sum2_max_reg;
    aat_pkg::coord_t       lo_reg;
    aat_pkg::coord_t       hi_reg;

    for (genvar t = 0; t < 3; t++)
    begin : g_term
        aat_fx_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_lo (
            .clk (clk),
            .en  (en),
            .a   (box_lo[t]),
            .b   (col[t]),
            .y   (prod_lo[t])
        );
        aat_fx_mul #(.FRAC_BITS(FRAC_BITS)) u_mul_hi (
            .clk (clk),
            .en  (en),
            .a   (box_hi[t]),
            .b   (col[t]),
            .y   (prod_hi[t])
        );
    end

    // products are monotone in the coordinate, so each term picks independently
    always_comb
    begin
        for (int t = 0; t < 3; t++)
        begin
            if ($signed(prod_lo[t]) < $signed(prod_hi[t]))
            begin
                term_min_next[t] = prod_lo[t];
                term_max_next[t] = prod_hi[t];
            end
            else
            begin
                term_min_next[t] = prod_hi[t];
                term_max_next[t] = prod_lo[t];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            trans_pipe_reg <= {trans_pipe_reg[3:0], trans};
            term_min_reg   <= term_min_next;
            term_max_reg   <= term_max_next;
            sum_min_reg    <= aat_pkg::sat_add(term_min_reg[0], term_min_reg[1]);
            sum_max_reg    <= aat_pkg::sat_add(term_max_reg[0], term_max_reg[1]);
            last_min_reg   <= term_min_reg[2];
            last_max_reg   <= term_max_reg[2];
            sum2_min_reg   <= aat_pkg::sat_add(sum_min_reg, last_min_reg);
            sum2_max_reg   <= aat_pkg::sat_add(sum_max_reg, last_max_reg);
            lo_reg         <= aat_pkg::sat_add(sum2_min_reg, trans_pipe_reg[4]);
            hi_reg         <= aat_pkg::sat_add(sum2_max_reg, trans_pipe_reg[4]);
        end
    end

    assign lo = lo_reg;
    assign hi = hi_reg;

endmodule

// ===== hdl/aabb_affine_transform_unit.sv =====
// top level of the box transform unit: config registers, valid pipeline, three axis units
// depends on aat_pkg and aat_axis
//
// Takes one affine matrix request per cycle and returns the world-space bounding box of
// the configured local box, one result per request, in order. A request passes the rounded
// multiply (product register, rounded result), min/max pick and saturating adds; the
// pipeline holds as a whole while the result register waits on out_ready, and takes a new
// request in the same cycle that a held result is taken. Box registers must be written
// through the cfg port while no request is in flight; the block does not enforce this.
// Writes to unused indexes are dropped; FRAC_BITS is the Q format fraction width (8 to 24).
module aabb_affine_transform_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  aat_pkg::in_t                         in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output aat_pkg::out_t                        out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [aat_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  aat_pkg::coord_t                      cfg_data
);

    localparam int DEPTH = aat_pkg::PIPE_DEPTH;

    aat_pkg::coord_t [2:0] box_lo_reg;
    aat_pkg::coord_t [2:0] box_hi_reg;
    logic [DEPTH-1:0]      valid_reg;
    logic                  en;
    aat_pkg::coord_t [2:0] axis_lo;
    aat_pkg::coord_t [2:0] axis_hi;
    aat_pkg::coord_t [2:0] col [3];
    aat_pkg::coord_t [2:0] trans;

    assign en        = !valid_reg[DEPTH-1] || out_ready;
    assign in_ready  = en;
    assign out_valid = valid_reg[DEPTH-1];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_lo_reg <= '0;
            box_hi_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (aat_pkg::cfg_index_t'(cfg_index))
                aat_pkg::CFG_BOX_MIN_X: box_lo_reg[0] <= cfg_data;
                aat_pkg::CFG_BOX_MIN_Y: box_lo_reg[1] <= cfg_data;
                aat_pkg::CFG_BOX_MIN_Z: box_lo_reg[2] <= cfg_data;
                aat_pkg::CFG_BOX_MAX_X: box_hi_reg[0] <= cfg_data;
                aat_pkg::CFG_BOX_MAX_Y: box_hi_reg[1] <= cfg_data;
                aat_pkg::CFG_BOX_MAX_Z: box_hi_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= {valid_reg[DEPTH-2:0], in_valid};
    end

    assign col[0] = {in_data.m20, in_data.m10, in_data.m00};
    assign col[1] = {in_data.m21, in_data.m11, in_data.m01};
    assign col[2] = {in_data.m22, in_data.m12, in_data.m02};
    assign trans  = {in_data.trans_z, in_data.trans_y, in_data.trans_x};

    for (genvar j = 0; j < 3; j++)
    begin : g_axis
        aat_axis #(.FRAC_BITS(FRAC_BITS)) u_axis (
            .clk    (clk),
            .en     (en),
            .box_lo (box_lo_reg),
            .box_hi (box_hi_reg),
            .col    (col[j]),
            .trans  (trans[j]),
            .lo     (axis_lo[j]),
            .hi     (axis_hi[j])
        );
    end

    assign out_data.world_min_x = axis_lo[0];
    assign out_data.world_min_y = axis_lo[1];
    assign out_data.world_min_z = axis_lo[2];
    assign out_data.world_max_x = axis_hi[0];
    assign out_data.world_max_y = axis_hi[1];
    assign out_data.world_max_z = axis_hi[2];

    a_min_le_max_x: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $signed(out_data.world_min_x) <= $signed(out_data.world_max_x))
        else $error("world x bounds out of order");

    a_min_le_max_y: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $signed(out_data.world_min_y) <= $signed(out_data.world_max_y))
        else $error("world y bounds out of order");

    a_min_le_max_z: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $signed(out_data.world_min_z) <= $signed(out_data.world_max_z))
        else $error("world z bounds out of order");

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("request taken while result held");

    a_cfg_write_max_z: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_index == aat_pkg::CFG_BOX_MAX_Z |=> box_hi_reg[2] == $past(cfg_data))
        else $error("box max z not written");

endmodule

// ===== verif/aat_checker.sv =====
// checker for the box transform unit: follows box register writes, predicts each world box
// and compares it with the result taken from the block; depends on aat_pkg
module aat_checker #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  aat_pkg::in_t                        in_data,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  aat_pkg::out_t                       out_data,
    input  logic                                cfg_valid,
    input  logic                                cfg_ready,
    input  logic [aat_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  aat_pkg::coord_t                     cfg_data,
    output int                                  pending,
    output int                                  errors
);

    localparam longint SAT_HI = aat_pkg::COORD_MAX;
    localparam longint SAT_LO = aat_pkg::COORD_MIN;

    aat_pkg::coord_t box_reg [6];
    aat_pkg::out_t   world_box_q [$];
    int              fail_count = 0;

    assign errors = fail_count;

    function automatic longint clamp(longint v);
        if (v > SAT_HI)
            return SAT_HI;
        if (v < SAT_LO)
            return SAT_LO;
        return v;
    endfunction

    // exact product, round half away from zero, saturate
    function automatic longint scale_round(aat_pkg::coord_t a, aat_pkg::coord_t b);
        logic        neg;
        longint      sa;
        longint      sb;
        longint      lim;
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] mag;
        sa  = a;
        sb  = b;
        neg = (sa < 0) != (sb < 0);
        ma  = (sa < 0) ? -sa : sa;
        mb  = (sb < 0) ? -sb : sb;
        mag = (ma * mb + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        lim = SAT_HI + (neg ? 1 : 0);
        if (mag > lim)
            return neg ? SAT_LO : SAT_HI;
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic aat_pkg::out_t predict_world_box(aat_pkg::in_t m);
        aat_pkg::coord_t mat [12];
        aat_pkg::coord_t c [3];
        longint          w;
        longint          mn [3];
        longint          mx [3];
        aat_pkg::out_t   r;
        mat = '{m.m00, m.m01, m.m02, m.m10, m.m11, m.m12,
                m.m20, m.m21, m.m22, m.trans_x, m.trans_y, m.trans_z};
        for (int k = 0; k < 8; k++)
        begin
            c[0] = (k & 4) ? box_reg[aat_pkg::CFG_BOX_MAX_X] : box_reg[aat_pkg::CFG_BOX_MIN_X];
            c[1] = (k & 2) ? box_reg[aat_pkg::CFG_BOX_MAX_Y] : box_reg[aat_pkg::CFG_BOX_MIN_Y];
            c[2] = (k & 1) ? box_reg[aat_pkg::CFG_BOX_MAX_Z] : box_reg[aat_pkg::CFG_BOX_MIN_Z];
            for (int j = 0; j < 3; j++)
            begin
                w = scale_round(c[0], mat[j]);
                w = clamp(w + scale_round(c[1], mat[3 + j]));
                w = clamp(w + scale_round(c[2], mat[6 + j]));
                w = clamp(w + mat[9 + j]);
                if (k == 0 || w < mn[j])
                    mn[j] = w;
                if (k == 0 || w > mx[j])
                    mx[j] = w;
            end
        end
        r.world_min_x = aat_pkg::coord_t'(mn[0]);
        r.world_min_y = aat_pkg::coord_t'(mn[1]);
        r.world_min_z = aat_pkg::coord_t'(mn[2]);
        r.world_max_x = aat_pkg::coord_t'(mx[0]);
        r.world_max_y = aat_pkg::coord_t'(mx[1]);
        r.world_max_z = aat_pkg::coord_t'(mx[2]);
        return r;
    endfunction

    task automatic check_field(string name, aat_pkg::coord_t want, aat_pkg::coord_t got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d (%h) actual %0d (%h)",
                     $time, name, want, want, got, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            foreach (box_reg[i])
                box_reg[i] = '0;
            world_box_q.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready && cfg_index <= aat_pkg::CFG_BOX_MAX_Z)
                box_reg[cfg_index] = cfg_data;
            if (out_valid && out_ready)
            begin
                if (world_box_q.size() == 0)
                begin
                    $display("%0t: unexpected result %h", $time, out_data);
                    fail_count++;
                end
                else
                begin
                    aat_pkg::out_t want;
                    want = world_box_q.pop_front();
                    check_field("world_min_x", want.world_min_x, out_data.world_min_x);
                    check_field("world_min_y", want.world_min_y, out_data.world_min_y);
                    check_field("world_min_z", want.world_min_z, out_data.world_min_z);
                    check_field("world_max_x", want.world_max_x, out_data.world_max_x);
                    check_field("world_max_y", want.world_max_y, out_data.world_max_y);
                    check_field("world_max_z", want.world_max_z, out_data.world_max_z);
                end
            end
            if (in_valid && in_ready)
                world_box_q.push_back(predict_world_box(in_data));
            pending <= world_box_q.size();
        end
    end

endmodule

// ===== verif/testbench.sv =====
// top of the box transform unit testbench: clock, reset, matrix requests, box writes, verdict
// depends on aat_pkg, aabb_affine_transform_unit and aat_checker
module testbench;

    localparam int              FRAC_BITS    = 16;
    localparam int              CLK_PERIOD   = 4;
    localparam int              HOLD_CYCLES  = 40;
    localparam int              RANDOM_ITEMS = 650;
    localparam int              LIMIT_CYCLES = 200000;
    localparam aat_pkg::coord_t ONE          = 32'sh0001_0000;

    logic                                clk;
    logic                                rst_n;
    logic                                in_valid;
    logic                                in_ready;
    aat_pkg::in_t                        in_data;
    logic                                out_valid;
    logic                                out_ready;
    aat_pkg::out_t                       out_data;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [aat_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    aat_pkg::coord_t                     cfg_data;
    int                                  pending;
    int                                  errors;
    int                                  send_idle_pct;
    int                                  recv_idle_pct;
    logic                                hold_toggle;

    aabb_affine_transform_unit #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    aat_checker #(
        .FRAC_BITS (FRAC_BITS)
    ) u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .errors    (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    initial
    begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side: random back-pressure, plus a long hold on each toggle request
    initial
    begin : receiver
        logic hold_seen;
        hold_seen = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_toggle)
            begin
                hold_seen = hold_toggle;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic aat_pkg::coord_t rand_coord(int mag_bits);
        int pick;
        pick = $urandom_range(9);
        if (pick == 0)
            return aat_pkg::coord_t'($urandom);
        if (pick == 1)
        begin
            case ($urandom_range(4))
                0:       return aat_pkg::COORD_MIN;
                1:       return aat_pkg::COORD_MAX;
                2:       return '0;
                3:       return ONE;
                default: return -ONE;
            endcase
        end
        return aat_pkg::coord_t'(int'($urandom_range((2 << mag_bits) - 1)) - (1 << mag_bits));
    endfunction

    function automatic aat_pkg::in_t rand_matrix(bit wild);
        aat_pkg::in_t m;
        if (wild)
            return aat_pkg::in_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                                   $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        m.m00     = rand_coord(18);
        m.m01     = rand_coord(18);
        m.m02     = rand_coord(18);
        m.m10     = rand_coord(18);
        m.m11     = rand_coord(18);
        m.m12     = rand_coord(18);
        m.m20     = rand_coord(18);
        m.m21     = rand_coord(18);
        m.m22     = rand_coord(18);
        m.trans_x = rand_coord(26);
        m.trans_y = rand_coord(26);
        m.trans_z = rand_coord(26);
        return m;
    endfunction

    function automatic aat_pkg::in_t scaled(aat_pkg::coord_t sx, aat_pkg::coord_t sy,
                                            aat_pkg::coord_t sz, aat_pkg::coord_t tx,
                                            aat_pkg::coord_t ty, aat_pkg::coord_t tz);
        aat_pkg::in_t m;
        m         = '0;
        m.m00     = sx;
        m.m11     = sy;
        m.m22     = sz;
        m.trans_x = tx;
        m.trans_y = ty;
        m.trans_z = tz;
        return m;
    endfunction

    function automatic aat_pkg::in_t filled(aat_pkg::coord_t v);
        return aat_pkg::in_t'({12{v}});
    endfunction

    task automatic send_matrix(input aat_pkg::in_t m);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= m;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input int idx, input aat_pkg::coord_t v);
        cfg_valid <= 1'b1;
        cfg_index <= idx[aat_pkg::CFG_INDEX_WIDTH-1:0];
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic write_box(input aat_pkg::coord_t b [6], input bit spare);
        for (int i = aat_pkg::CFG_BOX_MIN_X; i <= aat_pkg::CFG_BOX_MAX_Z; i++)
            write_reg(i, b[i]);
        if (spare)
            for (int i = aat_pkg::CFG_BOX_MAX_Z + 1; i < (1 << aat_pkg::CFG_INDEX_WIDTH); i++)
                write_reg(i, aat_pkg::coord_t'($urandom));
        cfg_valid <= 1'b0;
    endtask

    initial
    begin : stimulus
        aat_pkg::coord_t box [6];
        aat_pkg::in_t    rot;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        in_data       <= '0;
        out_ready     <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= '0;
        cfg_data      <= '0;
        hold_toggle   <= 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // box registers still at reset: result is the translation alone
        send_matrix(filled(32'sh5555_5555));

        wait_drained();
        box = '{-ONE, -2 * ONE, -3 * ONE, ONE, 2 * ONE, 3 * ONE};
        write_box(box, 1'b0);
        rot     = scaled('0, '0, ONE, 5 * ONE, '0, -7 * ONE);
        rot.m01 = ONE;
        rot.m10 = -ONE;
        send_matrix(scaled(ONE, ONE, ONE, '0, '0, '0));
        send_matrix(scaled(ONE, ONE, ONE, 10 * ONE, -20 * ONE, 30 * ONE));
        send_matrix('0);
        send_matrix(scaled(-ONE, -ONE, -ONE, ONE, ONE, ONE));
        send_matrix(rot);
        send_matrix(scaled(ONE * 5 / 2, ONE * 5 / 2, ONE * 5 / 2, '0, '0, '0));
        send_matrix(filled(32'shAAAA_AAAA));

        // widest box: products and sums saturate
        wait_drained();
        box = '{aat_pkg::COORD_MIN, aat_pkg::COORD_MIN, aat_pkg::COORD_MIN,
                aat_pkg::COORD_MAX, aat_pkg::COORD_MAX, aat_pkg::COORD_MAX};
        write_box(box, 1'b0);
        send_matrix(scaled(ONE, ONE, ONE, '0, '0, '0));
        send_matrix(filled(aat_pkg::COORD_MAX));
        send_matrix(filled(aat_pkg::COORD_MIN));
        send_matrix(scaled(ONE, ONE, ONE,
                           aat_pkg::COORD_MAX, aat_pkg::COORD_MAX, aat_pkg::COORD_MAX));
        send_matrix(scaled(ONE, ONE, ONE,
                           aat_pkg::COORD_MIN, aat_pkg::COORD_MIN, aat_pkg::COORD_MIN));
        send_matrix(filled(-1));

        // minimum above maximum, and writes to unused indexes
        wait_drained();
        box = '{5 * ONE, 5 * ONE, 5 * ONE, -5 * ONE, -5 * ONE, -5 * ONE};
        write_box(box, 1'b1);
        send_matrix(scaled(ONE, ONE, ONE, '0, '0, '0));
        send_matrix(rot);

        // tiny coordinates: rounding ties and values just below a tie
        wait_drained();
        box = '{32'sd1, -32'sd1, 32'sd3, 32'sh0001_0001, -32'sd3, 32'sh0001_8000};
        write_box(box, 1'b0);
        send_matrix(filled(32'sh0000_8000));
        send_matrix(filled(-32'sh0000_8000));
        send_matrix(filled(32'sh0000_7fff));
        send_matrix(filled(32'sh0001_8000));
        send_matrix(rand_matrix(1'b1));

        for (int phase = 0; phase < 3; phase++)
        begin
            wait_drained();
            send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 77 : 0;
            recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 21 : 0;
            foreach (box[i])
                box[i] = rand_coord(24);
            write_box(box, phase == 1);
            for (int n = 0; n < RANDOM_ITEMS / 3; n++)
            begin
                if (n == 60)
                    wait_drained();
                if (n == 100)
                    hold_toggle <= ~hold_toggle;
                send_matrix(rand_matrix($urandom_range(7) == 0));
            end
        end

        wait_drained();
        repeat (aat_pkg::PIPE_DEPTH * 4) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/aat_pkg.sv
hdl/aat_fx_mul.sv
hdl/aat_axis.sv
hdl/aabb_affine_transform_unit.sv
verif/aat_checker.sv
verif/testbench.sv
